// ----- sv/calu8_pkg.sv -----
// ----------------------------------------------------------------------------
// calu8_pkg
// command codes, flag positions and the word types shared by the alu files
// ----------------------------------------------------------------------------
`default_nettype none

package calu8_pkg;

  localparam int CmdW  = 5;
  localparam int DataW = 8;
  localparam int BitW  = 3;
  localparam int FlagW = 4;

  // command codes
  localparam logic [CmdW-1:0] CMD_ADD  = 5'd0;
  localparam logic [CmdW-1:0] CMD_ADC  = 5'd1;
  localparam logic [CmdW-1:0] CMD_SUB  = 5'd2;
  localparam logic [CmdW-1:0] CMD_SBC  = 5'd3;
  localparam logic [CmdW-1:0] CMD_AND  = 5'd4;
  localparam logic [CmdW-1:0] CMD_OR   = 5'd5;
  localparam logic [CmdW-1:0] CMD_XOR  = 5'd6;
  localparam logic [CmdW-1:0] CMD_CP   = 5'd7;
  localparam logic [CmdW-1:0] CMD_INC  = 5'd8;
  localparam logic [CmdW-1:0] CMD_DEC  = 5'd9;
  localparam logic [CmdW-1:0] CMD_DAA  = 5'd10;
  localparam logic [CmdW-1:0] CMD_CPL  = 5'd11;
  localparam logic [CmdW-1:0] CMD_CCF  = 5'd12;
  localparam logic [CmdW-1:0] CMD_SCF  = 5'd13;
  localparam logic [CmdW-1:0] CMD_RLC  = 5'd14;
  localparam logic [CmdW-1:0] CMD_RLCA = 5'd15;
  localparam logic [CmdW-1:0] CMD_RL   = 5'd16;
  localparam logic [CmdW-1:0] CMD_RLA  = 5'd17;
  localparam logic [CmdW-1:0] CMD_RRC  = 5'd18;
  localparam logic [CmdW-1:0] CMD_RRCA = 5'd19;
  localparam logic [CmdW-1:0] CMD_RR   = 5'd20;
  localparam logic [CmdW-1:0] CMD_RRA  = 5'd21;
  localparam logic [CmdW-1:0] CMD_SLA  = 5'd22;
  localparam logic [CmdW-1:0] CMD_SRA  = 5'd23;
  localparam logic [CmdW-1:0] CMD_SRL  = 5'd24;
  localparam logic [CmdW-1:0] CMD_SWAP = 5'd25;
  localparam logic [CmdW-1:0] CMD_BIT  = 5'd26;
  localparam logic [CmdW-1:0] CMD_SET  = 5'd27;
  localparam logic [CmdW-1:0] CMD_RES  = 5'd28;

  // flag bit positions
  localparam int FL_Z = 3;
  localparam int FL_N = 2;
  localparam int FL_H = 1;
  localparam int FL_C = 0;

  // decimal adjust constants
  localparam logic [DataW-1:0] DAA_HI    = 8'h60;
  localparam logic [DataW-1:0] DAA_LO    = 8'h06;
  localparam logic [DataW-1:0] DAA_LIMIT = 8'h99;
  localparam logic [3:0]       NIB_LIMIT = 4'h9;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [DataW-1:0] acc_in;
    logic [DataW-1:0] operand;
    logic [BitW-1:0]  bit_index;
    logic [FlagW-1:0] flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic [FlagW-1:0] flags_out;
    logic             write_result;
  } alu_out_t;

  function automatic logic is_zero(input logic [DataW-1:0] val);
    return (val == '0);
  endfunction

endpackage

`default_nettype wire

// ----- sv/calu8_core.sv -----
// ----------------------------------------------------------------------------
// calu8_core
// single pass combinational datapath: one command word in, one result word out
// ----------------------------------------------------------------------------
`default_nettype none

module calu8_core
  import calu8_pkg::*;
(
  input  alu_in_t  op_in,
  output alu_out_t op_out
);

  logic [DataW-1:0] a, v, r;
  logic [FlagW-1:0] fi, f;
  logic             cin, wr;
  logic             ci_add, ci_sub;
  logic [DataW:0]   sum9, diff9;
  logic [4:0]       hsum, hdiff;
  logic [DataW-1:0] daa1, daa2;
  logic             daa_c;
  logic [DataW-1:0] bmask;
  logic [DataW-1:0] rot_src;

  assign a   = op_in.acc_in;
  assign v   = op_in.operand;
  assign fi  = op_in.flags_in;
  assign cin = fi[FL_C];

  assign ci_add = (op_in.command == CMD_ADC) ? cin : 1'b0;
  assign ci_sub = (op_in.command == CMD_SBC) ? cin : 1'b0;

  assign sum9  = {1'b0, a} + {1'b0, v} + {{DataW{1'b0}}, ci_add};
  assign hsum  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, ci_add};
  // borrow out lands in the top bit
  assign diff9 = {1'b0, a} - {1'b0, v} - {{DataW{1'b0}}, ci_sub};
  assign hdiff = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, ci_sub};

  assign bmask = {{(DataW-1){1'b0}}, 1'b1} << op_in.bit_index;

  // accumulator forms rotate a, register forms rotate the operand
  assign rot_src = (op_in.command == CMD_RLCA || op_in.command == CMD_RLA ||
                    op_in.command == CMD_RRCA || op_in.command == CMD_RRA) ? a : v;

  // decimal adjust
  always_comb begin
    daa1  = a;
    daa2  = a;
    daa_c = cin;
    if (!fi[FL_N]) begin
      if (cin || (a > DAA_LIMIT)) begin
        daa1  = a + DAA_HI;
        daa_c = 1'b1;
      end
      daa2 = (fi[FL_H] || (a[3:0] > NIB_LIMIT)) ? daa1 + DAA_LO : daa1;
    end else begin
      daa1 = cin ? a - DAA_HI : a;
      daa2 = fi[FL_H] ? daa1 - DAA_LO : daa1;
    end
  end

  always_comb begin
    r  = a;
    f  = fi;
    wr = 1'b1;
    case (op_in.command)
      CMD_ADD, CMD_ADC: begin
        r = sum9[DataW-1:0];
        f = {is_zero(sum9[DataW-1:0]), 1'b0, hsum[4], sum9[DataW]};
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        r = (op_in.command == CMD_CP) ? a : diff9[DataW-1:0];
        f = {is_zero(diff9[DataW-1:0]), 1'b1, hdiff[4], diff9[DataW]};
        wr = (op_in.command != CMD_CP);
      end
      CMD_AND: begin
        r = a & v;
        f = {is_zero(a & v), 1'b0, 1'b1, 1'b0};
      end
      CMD_OR: begin
        r = a | v;
        f = {is_zero(a | v), 3'b000};
      end
      CMD_XOR: begin
        r = a ^ v;
        f = {is_zero(a ^ v), 3'b000};
      end
      CMD_INC: begin
        r = v + 8'd1;
        f = {is_zero(v + 8'd1), 1'b0, (v[3:0] == 4'hF), cin};
      end
      CMD_DEC: begin
        r = v - 8'd1;
        f = {is_zero(v - 8'd1), 1'b1, (v[3:0] == 4'h0), cin};
      end
      CMD_DAA: begin
        r = daa2;
        f = {is_zero(daa2), fi[FL_N], 1'b0, daa_c};
      end
      CMD_CPL: begin
        r = ~a;
        f = {fi[FL_Z], 1'b1, 1'b1, cin};
      end
      CMD_CCF: f = {fi[FL_Z], 2'b00, ~cin};
      CMD_SCF: f = {fi[FL_Z], 2'b00, 1'b1};
      CMD_RLC, CMD_RLCA: begin
        r = {rot_src[DataW-2:0], rot_src[DataW-1]};
        f = {(op_in.command == CMD_RLC) && is_zero(rot_src), 2'b00, rot_src[DataW-1]};
      end
      CMD_RL, CMD_RLA: begin
        r = {rot_src[DataW-2:0], cin};
        f = {(op_in.command == CMD_RL) && is_zero({rot_src[DataW-2:0], cin}), 2'b00,
             rot_src[DataW-1]};
      end
      CMD_RRC, CMD_RRCA: begin
        r = {rot_src[0], rot_src[DataW-1:1]};
        f = {(op_in.command == CMD_RRC) && is_zero(rot_src), 2'b00, rot_src[0]};
      end
      CMD_RR, CMD_RRA: begin
        r = {cin, rot_src[DataW-1:1]};
        f = {(op_in.command == CMD_RR) && is_zero({cin, rot_src[DataW-1:1]}), 2'b00,
             rot_src[0]};
      end
      CMD_SLA: begin
        r = {v[DataW-2:0], 1'b0};
        f = {is_zero({v[DataW-2:0], 1'b0}), 2'b00, v[DataW-1]};
      end
      CMD_SRA: begin
        r = {v[DataW-1], v[DataW-1:1]};
        f = {is_zero({v[DataW-1], v[DataW-1:1]}), 2'b00, v[0]};
      end
      CMD_SRL: begin
        r = {1'b0, v[DataW-1:1]};
        f = {is_zero({1'b0, v[DataW-1:1]}), 2'b00, v[0]};
      end
      CMD_SWAP: begin
        r = {v[3:0], v[7:4]};
        f = {is_zero(v), 3'b000};
      end
      CMD_BIT: begin
        r  = v;
        f  = {~v[op_in.bit_index], 1'b0, 1'b1, cin};
        wr = 1'b0;
      end
      CMD_SET: r = v | bmask;
      CMD_RES: r = v & ~bmask;
      default: wr = 1'b0;
    endcase
  end

  assign op_out.result       = r;
  assign op_out.flags_out    = f;
  assign op_out.write_result = wr;

endmodule

`default_nettype wire

// ----- sv/cpu_alu8_with_flags.sv -----
// ----------------------------------------------------------------------------
// cpu_alu8_with_flags
// eight-bit cpu alu with z/n/h/c flags, registered in and out
// ----------------------------------------------------------------------------
// A command word is taken at every rising edge with start high; busy is tied
// low, so a new word may follow in every cycle. Each word passes an input
// register, one pass of combinational alu logic and a result register, so its
// result shows on result, flags_out and write_result with done high once the
// result register has taken it, for one cycle only. The receiver cannot stall:
// it must take each result in the cycle done is high. Throughput is one word
// per cycle, set by the single alu pass between the two registers.
// write_result is low for compare, bit test and unused command codes.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_alu8_with_flags
  import calu8_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [CmdW-1:0]  command,
  input  wire logic [DataW-1:0] acc_in,
  input  wire logic [DataW-1:0] operand,
  input  wire logic [BitW-1:0]  bit_index,
  input  wire logic [FlagW-1:0] flags_in,
  output logic                  done,
  output logic [DataW-1:0]      result,
  output logic [FlagW-1:0]      flags_out,
  output logic                  write_result
);

  // input stage
  alu_in_t  in_word;
  logic     in_valid;
  // alu output, before the result register
  alu_out_t alu_word;
  alu_out_t out_word;

  // never stalls: a word can enter every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      in_word <= '{command: command, acc_in: acc_in, operand: operand,
                   bit_index: bit_index, flags_in: flags_in};
    end
  end

  calu8_core u_core (
    .op_in  (in_word),
    .op_out (alu_word)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_word <= alu_word;
    end
  end

  assign result       = out_word.result;
  assign flags_out    = out_word.flags_out;
  assign write_result = out_word.write_result;

`ifndef ASSERT_OFF
  // every accepted word shows done once it has passed the input and result registers
  a_start_to_done: assert property (@(posedge clk) disable iff (rst)
    start ##1 !rst |=> done)
    else $error("accepted word did not produce a result");

  // no result without an accepted word
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("result strobe without an input word");

  // set and res never touch the flags
  a_set_res_keep_flags: assert property (@(posedge clk) disable iff (rst)
    in_valid && (in_word.command == CMD_SET || in_word.command == CMD_RES)
    |=> flags_out == $past(in_word.flags_in))
    else $error("set or res changed the flags");

  // compare and bit test are never written back
  a_cp_bit_no_write: assert property (@(posedge clk) disable iff (rst)
    in_valid && (in_word.command == CMD_CP || in_word.command == CMD_BIT)
    |=> !write_result)
    else $error("cp or bit flagged for write back");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the eight-bit alu with z/n/h/c flags
// ----------------------------------------------------------------------------
// A short table of directed words walks every command, the operand extremes,
// compare and bit test without write-back, the decimal adjust paths and one
// unused command code. Some rows carry a hand-typed answer. About 1400 random
// words follow. Words without a hand-typed answer are predicted by a local
// model of the alu; each done strobe is checked field by field against the
// oldest prediction. The sender idles at random and drains the alu three times.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import calu8_pkg::*;

  localparam int ClkHigh     = 6;
  localparam int ClkLow      = 6;
  localparam int ResetCycles = 6;
  localparam int GapMax      = 16;
  localparam int RandomWords = 1400;
  localparam int DrainCycles = 4;
  localparam int CycleLimit  = 200000;

  // codes past res carry no operation
  localparam logic [CmdW-1:0] CMD_SPARE_LO = CMD_RES + 1'b1;
  localparam logic [CmdW-1:0] CMD_SPARE_HI = '1;

  // one directed row: the word, and optionally a hand-typed answer
  typedef struct packed {
    alu_in_t  word;
    logic     pinned;
    alu_out_t answer;
  } alu_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic [CmdW-1:0]  command   = '0;
  logic [DataW-1:0] acc_in    = '0;
  logic [DataW-1:0] operand   = '0;
  logic [BitW-1:0]  bit_index = '0;
  logic [FlagW-1:0] flags_in  = '0;
  logic             busy;
  logic             done;
  logic [DataW-1:0] result;
  logic [FlagW-1:0] flags_out;
  logic             write_result;

  // hand-typed answer that travels along with the word being offered
  logic     pin_valid = 1'b0;
  alu_out_t pin_answer = '0;

  alu_out_t    pending_results[$];
  alu_row_t    directed_rows[$];
  alu_in_t     taken_word;
  alu_out_t    oldest;
  bit [31:0]   cmd_seen = '0;
  int          fail_count = 0;
  int          words_taken = 0;
  int          results_checked = 0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  always begin
    #ClkHigh clk = 1'b1;
    #ClkLow  clk = 1'b0;
  end

  cpu_alu8_with_flags dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .acc_in       (acc_in),
    .operand      (operand),
    .bit_index    (bit_index),
    .flags_in     (flags_in),
    .done         (done),
    .result       (result),
    .flags_out    (flags_out),
    .write_result (write_result)
  );

  // --------------------------------------------------------------------------
  // alu behavior: new value, new flags and write-back for one command word
  // --------------------------------------------------------------------------
  function automatic alu_out_t calc_alu_word(input alu_in_t w);
    logic [DataW-1:0] a, v, r, src;
    logic [FlagW-1:0] fi, fo;
    logic [DataW:0]   wide;
    logic [4:0]       nib;
    logic             ci, c, wr, shift_op, acc_form;
    alu_out_t         o;
    a        = w.acc_in;
    v        = w.operand;
    fi       = w.flags_in;
    r        = a;
    fo       = fi;
    wr       = 1'b1;
    c        = 1'b0;
    shift_op = 1'b0;
    acc_form = 1'b0;
    // accumulator forms of the rotates work on a, the cb forms on the operand
    acc_form = (w.command == CMD_RLCA) || (w.command == CMD_RLA) ||
               (w.command == CMD_RRCA) || (w.command == CMD_RRA);
    src      = acc_form ? a : v;
    case (w.command)
      CMD_ADD, CMD_ADC: begin
        ci   = (w.command == CMD_ADC) && fi[FL_C];
        wide = {1'b0, a} + {1'b0, v} + {{DataW{1'b0}}, ci};
        nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, ci};
        r    = wide[DataW-1:0];
        fo   = '0;
        fo[FL_Z] = (r == '0);
        fo[FL_H] = nib[4];
        fo[FL_C] = wide[DataW];
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        ci   = (w.command == CMD_SBC) && fi[FL_C];
        // the top bit of the widened difference is the borrow
        wide = {1'b0, a} - {1'b0, v} - {{DataW{1'b0}}, ci};
        nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, ci};
        fo   = '0;
        fo[FL_Z] = (wide[DataW-1:0] == '0);
        fo[FL_N] = 1'b1;
        fo[FL_H] = nib[4];
        fo[FL_C] = wide[DataW];
        if (w.command == CMD_CP) begin
          r  = a;
          wr = 1'b0;
        end else begin
          r = wide[DataW-1:0];
        end
      end
      CMD_AND: begin
        r  = a & v;
        fo = '0;
        fo[FL_Z] = (r == '0);
        fo[FL_H] = 1'b1;
      end
      CMD_OR: begin
        r  = a | v;
        fo = '0;
        fo[FL_Z] = (r == '0);
      end
      CMD_XOR: begin
        r  = a ^ v;
        fo = '0;
        fo[FL_Z] = (r == '0);
      end
      CMD_INC: begin
        r  = v + 8'd1;
        fo = '0;
        fo[FL_Z] = (r == '0);
        fo[FL_H] = (v[3:0] == 4'hf);
        fo[FL_C] = fi[FL_C];
      end
      CMD_DEC: begin
        r  = v - 8'd1;
        fo = '0;
        fo[FL_Z] = (r == '0);
        fo[FL_N] = 1'b1;
        fo[FL_H] = (v[3:0] == 4'h0);
        fo[FL_C] = fi[FL_C];
      end
      CMD_DAA: begin
        c = fi[FL_C];
        if (!fi[FL_N]) begin
          if (fi[FL_C] || (a > 8'h99)) begin
            r = r + 8'h60;
            c = 1'b1;
          end
          if (fi[FL_H] || (a[3:0] > 4'h9)) r = r + 8'h06;
        end else begin
          if (fi[FL_C]) r = r - 8'h60;
          if (fi[FL_H]) r = r - 8'h06;
        end
        fo = '0;
        fo[FL_Z] = (r == '0);
        fo[FL_N] = fi[FL_N];
        fo[FL_C] = c;
      end
      CMD_CPL: begin
        r  = ~a;
        fo[FL_N] = 1'b1;
        fo[FL_H] = 1'b1;
      end
      CMD_CCF: begin
        fo = '0;
        fo[FL_Z] = fi[FL_Z];
        fo[FL_C] = ~fi[FL_C];
      end
      CMD_SCF: begin
        fo = '0;
        fo[FL_Z] = fi[FL_Z];
        fo[FL_C] = 1'b1;
      end
      CMD_RLC, CMD_RLCA: begin
        shift_op = 1'b1;
        c = src[7];
        r = {src[6:0], c};
      end
      CMD_RL, CMD_RLA: begin
        shift_op = 1'b1;
        c = src[7];
        r = {src[6:0], fi[FL_C]};
      end
      CMD_RRC, CMD_RRCA: begin
        shift_op = 1'b1;
        c = src[0];
        r = {c, src[7:1]};
      end
      CMD_RR, CMD_RRA: begin
        shift_op = 1'b1;
        c = src[0];
        r = {fi[FL_C], src[7:1]};
      end
      CMD_SLA: begin
        shift_op = 1'b1;
        c = v[7];
        r = {v[6:0], 1'b0};
      end
      CMD_SRA: begin
        shift_op = 1'b1;
        c = v[0];
        r = {v[7], v[7:1]};
      end
      CMD_SRL: begin
        shift_op = 1'b1;
        c = v[0];
        r = {1'b0, v[7:1]};
      end
      CMD_SWAP: begin
        r  = {v[3:0], v[7:4]};
        fo = '0;
        fo[FL_Z] = (r == '0);
      end
      CMD_BIT: begin
        r  = v;
        wr = 1'b0;
        fo = '0;
        fo[FL_Z] = ~v[w.bit_index];
        fo[FL_H] = 1'b1;
        fo[FL_C] = fi[FL_C];
      end
      CMD_SET: r = v | (8'h01 << w.bit_index);
      CMD_RES: r = v & ~(8'h01 << w.bit_index);
      default: begin
        r  = a;
        fo = fi;
        wr = 1'b0;
      end
    endcase
    // rotates and shifts: z only for the cb forms, n and h always clear
    if (shift_op) begin
      fo = '0;
      fo[FL_Z] = !acc_form && (r == '0);
      fo[FL_C] = c;
    end
    o.result       = r;
    o.flags_out    = fo;
    o.write_result = wr;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // monitor: results first, then the word taken at this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      // the receiver cannot stall, so every done cycle is one result
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("done strobe with no word outstanding");
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          results_checked++;
          if (result !== oldest.result) begin
            $error("result: expected %h, got %h", oldest.result, result);
            fail_count++;
          end
          if (flags_out !== oldest.flags_out) begin
            $error("flags_out: expected %h, got %h", oldest.flags_out, flags_out);
            fail_count++;
          end
          if (write_result !== oldest.write_result) begin
            $error("write_result: expected %b, got %b",
                   oldest.write_result, write_result);
            fail_count++;
          end
        end
      end
      // a word is taken where start is high and busy low
      if (start && !busy) begin
        taken_word.command   = command;
        taken_word.acc_in    = acc_in;
        taken_word.operand   = operand;
        taken_word.bit_index = bit_index;
        taken_word.flags_in  = flags_in;
        pending_results.push_back(pin_valid ? pin_answer : calc_alu_word(taken_word));
        cmd_seen[command] = 1'b1;
        words_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  task automatic add_row(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] a,
                         input logic [DataW-1:0] v, input logic [BitW-1:0] b,
                         input logic [FlagW-1:0] f, input logic pinned,
                         input logic [DataW-1:0] r, input logic [FlagW-1:0] fo,
                         input logic wr);
    alu_row_t row;
    row.word   = '{command: cmd, acc_in: a, operand: v, bit_index: b, flags_in: f};
    row.pinned = pinned;
    row.answer = '{result: r, flags_out: fo, write_result: wr};
    directed_rows.push_back(row);
  endtask

  // offer one word after a random idle gap, return at the edge that takes it
  task automatic send_word(input alu_in_t w, input logic pinned, input alu_out_t answer);
    int gap;
    if (burst_left > 0) begin
      // back-to-back stretch
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, GapMax);
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      // idle: the fields carry junk the alu must ignore
      start     <= 1'b0;
      command   <= CmdW'($urandom);
      acc_in    <= DataW'($urandom);
      operand   <= DataW'($urandom);
      bit_index <= BitW'($urandom);
      flags_in  <= FlagW'($urandom);
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    command    <= w.command;
    acc_in     <= w.acc_in;
    operand    <= w.operand;
    bit_index  <= w.bit_index;
    flags_in   <= w.flags_in;
    pin_valid  <= pinned;
    pin_answer <= answer;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic alu_in_t rand_word();
    alu_in_t w;
    // a few percent of words use the spare codes
    if ($urandom_range(0, 99) < 4)
      w.command = CmdW'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    else
      w.command = CmdW'($urandom_range(CMD_ADD, CMD_RES));
    w.acc_in    = DataW'($urandom_range(0, 255));
    w.operand   = DataW'($urandom_range(0, 255));
    w.bit_index = BitW'($urandom_range(0, 7));
    w.flags_in  = FlagW'($urandom_range(0, 15));
    return w;
  endfunction

  initial begin
    int codes_hit;
    // directed table: pinned rows carry an answer read straight off the spec
    add_row(CMD_ADD,  8'hff, 8'h01, 3'd0, 4'h0, 1'b1, 8'h00, 4'hb, 1'b1); // wrap to zero
    add_row(CMD_ADC,  8'hff, 8'hff, 3'd0, 4'h1, 1'b1, 8'hff, 4'h3, 1'b1); // max with carry
    add_row(CMD_SUB,  8'h00, 8'h01, 3'd0, 4'h0, 1'b1, 8'hff, 4'h7, 1'b1); // full borrow
    add_row(CMD_SBC,  8'h10, 8'h0f, 3'd0, 4'h1, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_AND,  8'hf0, 8'h0f, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_OR,   8'h00, 8'h00, 3'd0, 4'hf, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_XOR,  8'hff, 8'hff, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_CP,   8'h42, 8'h42, 3'd0, 4'h0, 1'b1, 8'h42, 4'hc, 1'b0); // equal, no write
    add_row(CMD_INC,  8'h00, 8'hff, 3'd0, 4'h1, 1'b1, 8'h00, 4'hb, 1'b1); // wrap, c kept
    add_row(CMD_DEC,  8'h00, 8'h00, 3'd0, 4'h0, 1'b1, 8'hff, 4'h6, 1'b1); // wrap down
    add_row(CMD_DAA,  8'h9a, 8'h00, 3'd0, 4'h0, 1'b1, 8'h00, 4'h9, 1'b1); // both nibbles
    add_row(CMD_DAA,  8'h00, 8'h00, 3'd0, 4'h7, 1'b0, 8'h00, 4'h0, 1'b0); // after subtract
    add_row(CMD_CPL,  8'h5a, 8'h00, 3'd0, 4'h9, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_CCF,  8'h33, 8'h00, 3'd0, 4'hf, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_SCF,  8'h77, 8'h00, 3'd0, 4'h6, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_RLC,  8'h00, 8'h80, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_RLCA, 8'h00, 8'h00, 3'd0, 4'hf, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_RL,   8'h00, 8'h80, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_RLA,  8'h80, 8'h00, 3'd0, 4'h1, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_RRC,  8'h00, 8'h01, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_RRCA, 8'h01, 8'h00, 3'd0, 4'h8, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_RR,   8'h00, 8'h01, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_RRA,  8'h00, 8'h00, 3'd0, 4'h1, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_SLA,  8'h00, 8'h80, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_SRA,  8'h00, 8'h81, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_SRL,  8'h00, 8'h01, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_SWAP, 8'h00, 8'hf0, 3'd0, 4'h0, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_BIT,  8'h00, 8'h7f, 3'd7, 4'h1, 1'b1, 8'h7f, 4'hb, 1'b0); // clear bit
    add_row(CMD_SET,  8'h00, 8'h00, 3'd7, 4'h5, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_RES,  8'h00, 8'hff, 3'd0, 4'ha, 1'b0, 8'h00, 4'h0, 1'b0);
    add_row(CMD_SPARE_HI, 8'h12, 8'h34, 3'd5, 4'hc, 1'b1, 8'h12, 4'hc, 1'b0); // no operation

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_word(directed_rows[k].word, directed_rows[k].pinned, directed_rows[k].answer);

    // let the pipe run dry before the random part
    wait_idle();

    for (int i = 0; i < RandomWords; i++) begin
      if (i == RandomWords / 2) wait_idle();
      send_word(rand_word(), 1'b0, '0);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never came back", pending_results.size());
      fail_count++;
    end

    codes_hit = $countones(cmd_seen);
    $display("%0d words taken (%0d from the directed table), %0d results checked",
             words_taken, directed_rows.size(), results_checked);
    $display("%0d of 32 command codes exercised, %0d mismatches", codes_hit, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $error("timeout after %0d cycles", CycleLimit);
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
